>>> src/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants for the cascaded clock with segment scan
// Register indexes, request codes, digit count and the seven-segment decoder.
// ----------------------------------------------------------------------------
package ccs_pkg;

	// number of display digits in the buffer and the width of a scan position
	localparam int DIGITS = 6;
	localparam int POS_W  = $clog2(DIGITS);

	// width of the digit_select output field
	localparam int SEL_W = 6;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SCAN_DIVIDE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_DIVIDE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SECONDS_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MINUTES_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOURS_LIMIT   = 3'd4;

	// request codes passed from front to back
	typedef logic op_t;
	localparam op_t OP_IDLE = 1'b0;   // no time passes, only report the LED
	localparam op_t OP_TICK = 1'b1;   // one millisecond, run the counter chain

	// request queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// segment patterns
	localparam logic [6:0] SEG_ZERO  = 7'h3f;
	localparam logic [6:0] SEG_BLANK = 7'h00;

	typedef struct packed {
		logic [7:0] scan_divide;
		logic [7:0] second_divide;
		logic [6:0] seconds_limit;
		logic [6:0] minutes_limit;
		logic [6:0] hours_limit;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// decimal digit to segment pattern, bit0 = a .. bit6 = g
	function automatic logic [6:0] seg_of(input logic [3:0] d);
		logic [6:0] p;
		case (d)
			4'd0: p = 7'h3f;
			4'd1: p = 7'h06;
			4'd2: p = 7'h5b;
			4'd3: p = 7'h4f;
			4'd4: p = 7'h66;
			4'd5: p = 7'h6d;
			4'd6: p = 7'h7d;
			4'd7: p = 7'h07;
			4'd8: p = 7'h7f;
			4'd9: p = 7'h6f;
			default: p = SEG_BLANK;
		endcase
		return p;
	endfunction

endpackage

>>> src/ccs_front.sv
// ----------------------------------------------------------------------------
// ccs_front: input stage
// Takes tick requests, classifies them into request codes and feeds the queue.
// ----------------------------------------------------------------------------
module ccs_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             tick,
	input  ccs_pkg::q_stat_t q_stat,
	output logic             q_push,
	output ccs_pkg::op_t     q_op
);

	logic         valid_s1;
	ccs_pkg::op_t op_s1;
	logic         take;

	assign q_push   = valid_s1 & ~q_stat.full;
	assign q_op     = op_s1;
	assign in_stall = valid_s1 & q_stat.full;
	assign take     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= tick ? ccs_pkg::OP_TICK : ccs_pkg::OP_IDLE;
		end
	end

endmodule

>>> src/ccs_queue.sv
// ----------------------------------------------------------------------------
// ccs_queue: request queue
// Small FIFO of request codes between the front and back parts.
// ----------------------------------------------------------------------------
module ccs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ccs_pkg::op_t     push_op,
	input  logic             pop,
	output ccs_pkg::op_t     pop_op,
	output ccs_pkg::q_stat_t stat
);

	ccs_pkg::op_t                 mem_q [ccs_pkg::QDEPTH];
	logic [ccs_pkg::QPTR_W-1:0]   wr_q;
	logic [ccs_pkg::QPTR_W-1:0]   rd_q;
	logic [ccs_pkg::QCNT_W-1:0]   cnt_q;

	assign stat.full  = (cnt_q == ccs_pkg::QCNT_W'(ccs_pkg::QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_op     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_op;
		end
	end

endmodule

>>> src/ccs_back.sv
// ----------------------------------------------------------------------------
// ccs_back: execution sequencer
// Runs the counter chain, converts counts to digits and drives the result.
// ----------------------------------------------------------------------------
module ccs_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ccs_pkg::cfg_t              cfg,
	input  ccs_pkg::q_stat_t           q_stat,
	input  ccs_pkg::op_t               q_op,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       strobe_res,
	output logic [ccs_pkg::SEL_W-1:0]  digit_select,
	output logic [6:0]                 segments,
	output logic                       led
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CASC = 3'd1;
	localparam logic [2:0] ST_SEC  = 3'd2;
	localparam logic [2:0] ST_MIN  = 3'd3;
	localparam logic [2:0] ST_HOUR = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;

	logic [7:0] scan_q, sub_q, sec_q, min_q, hour_q;
	logic [ccs_pkg::POS_W-1:0] pos_q;
	logic led_q;
	logic [6:0] buf_q [ccs_pkg::DIGITS];

	logic f_sec_q, f_min_q, f_hour_q;
	logic strobe_q;
	logic [ccs_pkg::SEL_W-1:0] sel_q;
	logic [6:0] seg_q;

	logic out_valid_q;
	logic load_out;

	// counter chain
	logic [7:0] scan_sum, sub_sum, sec_sum, min_sum, hour_sum;
	logic w_scan, w_sub, w_sec, w_min;

	// digit conversion
	logic [7:0]  conv_val;
	logic [15:0] conv_prod;
	logic [4:0]  tens;
	logic [7:0]  tens_x10;
	logic [3:0]  ones;
	logic [6:0]  seg_ones, seg_tens;
	logic        conv_en;
	logic [3:0]  base, base_hi;
	logic [ccs_pkg::SEL_W-1:0] sel_now;

	assign q_pop    = (state_q == ST_IDLE) & ~q_stat.empty;
	assign load_out = (state_q == ST_DONE) & (~out_valid_q | ~out_stall);

	always_comb begin
		scan_sum = scan_q + 8'd1;
		sub_sum  = sub_q + 8'd1;
		sec_sum  = sec_q + 8'd1;
		min_sum  = min_q + 8'd1;
		hour_sum = hour_q + 8'd1;
		w_scan   = (scan_sum == cfg.scan_divide);
		w_sub    = w_scan & (sub_sum == cfg.second_divide);
		w_sec    = w_sub & (sec_sum == {1'b0, cfg.seconds_limit});
		w_min    = w_sec & (min_sum == {1'b0, cfg.minutes_limit});
	end

	always_comb begin
		for (int i = 0; i < ccs_pkg::SEL_W; i++) begin
			sel_now[i] = (i < ccs_pkg::DIGITS) && (int'(pos_q) == i);
		end
	end

	// value / 10 as (v * 205) >> 11, exact for 8-bit v
	always_comb begin
		case (state_q)
			ST_SEC: begin
				conv_val = sec_q;
				conv_en  = f_sec_q;
				base     = 4'd0;
			end
			ST_MIN: begin
				conv_val = min_q;
				conv_en  = f_min_q;
				base     = 4'd2;
			end
			ST_HOUR: begin
				conv_val = hour_q;
				conv_en  = f_hour_q;
				base     = 4'd4;
			end
			default: begin
				conv_val = sec_q;
				conv_en  = 1'b0;
				base     = 4'd0;
			end
		endcase
		base_hi   = base + 4'd1;
		conv_prod = 16'(conv_val) * 16'd205;
		tens      = conv_prod[15:11];
		tens_x10  = 8'({tens, 3'b000}) + 8'({tens, 1'b0});
		ones      = 4'(conv_val - tens_x10);
		seg_ones  = ccs_pkg::seg_of(ones);
		seg_tens  = (tens < 5'd10) ? ccs_pkg::seg_of(tens[3:0]) : ccs_pkg::SEG_BLANK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			sub_q       <= '0;
			sec_q       <= '0;
			min_q       <= '0;
			hour_q      <= '0;
			pos_q       <= '0;
			led_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < ccs_pkg::DIGITS; i++) begin
				buf_q[i] <= ccs_pkg::SEG_ZERO;
			end
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (~out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= (q_op == ccs_pkg::OP_TICK) ? ST_CASC : ST_DONE;
					end
				end
				ST_CASC: begin
					scan_q <= w_scan ? 8'd0 : scan_sum;
					if (w_scan) begin
						sub_q <= w_sub ? 8'd0 : sub_sum;
						if (pos_q == ccs_pkg::POS_W'(ccs_pkg::DIGITS - 1)) begin
							pos_q <= '0;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
					if (w_sub) begin
						sec_q <= w_sec ? 8'd0 : sec_sum;
						led_q <= ~led_q;
					end
					if (w_sec) begin
						min_q <= w_min ? 8'd0 : min_sum;
					end
					if (w_min) begin
						hour_q <= (hour_sum == {1'b0, cfg.hours_limit}) ? 8'd0 : hour_sum;
					end
					state_q <= ST_SEC;
				end
				ST_SEC: begin
					state_q <= ST_MIN;
				end
				ST_MIN: begin
					state_q <= ST_HOUR;
				end
				ST_HOUR: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (conv_en) begin
				if (int'(base) < ccs_pkg::DIGITS) begin
					buf_q[base[ccs_pkg::POS_W-1:0]] <= seg_ones;
				end
				if (int'(base_hi) < ccs_pkg::DIGITS) begin
					buf_q[base_hi[ccs_pkg::POS_W-1:0]] <= seg_tens;
				end
			end
		end
	end

	// per-request result and flags; strobe reads the buffer before any update
	always_ff @(posedge clk) begin
		if (q_pop) begin
			strobe_q <= 1'b0;
			sel_q    <= '0;
			seg_q    <= '0;
			f_sec_q  <= 1'b0;
			f_min_q  <= 1'b0;
			f_hour_q <= 1'b0;
		end else if (state_q == ST_CASC) begin
			strobe_q <= w_scan;
			sel_q    <= w_scan ? sel_now : '0;
			seg_q    <= w_scan ? buf_q[pos_q] : 7'd0;
			f_sec_q  <= w_sub;
			f_min_q  <= w_sec;
			f_hour_q <= w_min;
		end
		if (load_out) begin
			strobe_res   <= strobe_q;
			digit_select <= sel_q;
			segments     <= seg_q;
			led          <= led_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> src/cascaded_clock_with_segment_scan.sv
// ----------------------------------------------------------------------------
// cascaded_clock_with_segment_scan: millisecond clock with multiplexed display
// Chained scan / sub-second / seconds / minutes / hours counters that refresh
// a six-digit seven-segment buffer and strobe one digit per scan period.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_stall    | tick
//  out     | out_valid / out_stall  | strobe_res, digit_select, segments, led
//  cfg     | cfg_we (no wait)       | cfg_index, cfg_data
//
// Every request gives one result. The back sequencer runs a tick request
// through the counter chain, three digit conversions through one shared
// divide-by-ten unit and the output load; an idle request goes straight to
// the output load. These states set the rate. The front stage and a 2-entry
// request queue take requests while out_stall holds the output, until full.
// Reset puts all counters at zero, the LED off and every digit at the zero
// pattern; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cascaded_clock_with_segment_scan (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [ccs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ccs_pkg::CFG_DATA_W-1:0]    cfg_data,
	// request channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              tick,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              strobe_res,
	output logic [ccs_pkg::SEL_W-1:0]         digit_select,
	output logic [6:0]                        segments,
	output logic                              led
);

	ccs_pkg::cfg_t    cfg_q;
	ccs_pkg::q_stat_t q_stat;
	ccs_pkg::op_t     push_op, pop_op;
	logic             q_push, q_pop;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_divide   <= 8'd4;
			cfg_q.second_divide <= 8'd250;
			cfg_q.seconds_limit <= 7'd60;
			cfg_q.minutes_limit <= 7'd60;
			cfg_q.hours_limit   <= 7'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				ccs_pkg::REG_SCAN_DIVIDE:   cfg_q.scan_divide   <= cfg_data;
				ccs_pkg::REG_SECOND_DIVIDE: cfg_q.second_divide <= cfg_data;
				ccs_pkg::REG_SECONDS_LIMIT: cfg_q.seconds_limit <= cfg_data[6:0];
				ccs_pkg::REG_MINUTES_LIMIT: cfg_q.minutes_limit <= cfg_data[6:0];
				ccs_pkg::REG_HOURS_LIMIT:   cfg_q.hours_limit   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// front: accept and classify
	ccs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.tick     (tick),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_op     (push_op)
	);

	// request queue
	ccs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (push_op),
		.pop     (q_pop),
		.pop_op  (pop_op),
		.stat    (q_stat)
	);

	// back: counter chain, digit buffer, result register
	ccs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_stat       (q_stat),
		.q_op         (pop_op),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.strobe_res   (strobe_res),
		.digit_select (digit_select),
		.segments     (segments),
		.led          (led)
	);

endmodule
